/* hw/rtl/iis_pkg.sv */
// Package for the integer interval set: word types, table sizes and operation codes.
// No dependencies.
package iis_pkg;

  localparam int MaxRanges = 64;
  localparam int IdxW = $clog2(MaxRanges);
  localparam int CntW = $clog2(MaxRanges + 1);

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_ADD = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic was_member;
    logic member_found;
    logic signed [31:0] next_member;
    logic signed [31:0] next_free;
    logic table_full;
    logic set_empty;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic shift_up;
    logic shift_down;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_up_done;
    logic shift_down_done;
    logic need_up;
    logic need_down;
  } status_t;

endpackage

/* hw/rtl/iis_ctrl.sv */
// Controller for the integer interval set: sequences scan, decision, shift and output.
// Depends on iis_pkg.
module iis_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_busy,
  input  iis_pkg::status_t status,
  output logic             in_ready,
  output iis_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UP = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_START = 3'd6;
  localparam logic [2:0] S_ROUTE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_ROUTE;
      end
      S_ROUTE: begin
        if (status.need_up) begin
          state_next = S_UP;
        end else if (status.need_down) begin
          state_next = S_DOWN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UP: begin
        cmd.shift_up = 1'b1;
        if (status.shift_up_done) begin
          state_next = S_DONE;
        end
      end
      S_DOWN: begin
        cmd.shift_down = 1'b1;
        if (status.shift_down_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_load_next: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_START) else $error("load did not start scan");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_busy) else $error("finish while output busy");
`endif

endmodule

/* hw/rtl/iis_dp.sv */
// Datapath for the integer interval set: range table memory, scan and shift engine.
// Depends on iis_pkg.
module iis_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  iis_pkg::cmd_t        cmd,
  input  iis_pkg::in_word_t    in_word,
  output iis_pkg::status_t     status,
  output iis_pkg::out_word_t   result
);

  localparam int IdxW = iis_pkg::IdxW;
  localparam int CntW = iis_pkg::CntW;

  logic signed [32:0] mem_start [iis_pkg::MaxRanges];
  logic signed [32:0] mem_end [iis_pkg::MaxRanges];

  logic [CntW-1:0] count;
  logic [1:0] kind;
  logic signed [32:0] key;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] f;
  logic f_set;
  logic signed [32:0] nfree;
  logic nfree_stop;
  logic signed [32:0] prev_end;
  logic signed [32:0] f_start;
  logic signed [32:0] f_end;
  logic rd_valid;
  logic signed [32:0] rd_start;
  logic signed [32:0] rd_end;
  logic [CntW-1:0] rd_idx;
  logic full;
  logic need_up;
  logic need_down;
  logic [CntW-1:0] sh_idx;
  logic [CntW-1:0] sh_stop;
  logic signed [32:0] ins_start;
  logic signed [32:0] ins_end;
  logic [IdxW-1:0] rd_addr;
  logic signed [32:0] key1;
  logic hit;
  logic join_left;
  logic join_right;
  logic cut_start;
  logic cut_end;
  logic is_full;
  logic refused;

  assign key1 = key + 33'sd1;
  assign hit = f_set && f_start <= key;
  assign join_left = f != '0 && prev_end == key;
  assign join_right = f_set && f_start == key1;
  assign cut_start = f_start == key;
  assign cut_end = f_end == key1;
  assign is_full = count >= CntW'(iis_pkg::MaxRanges);
  assign full = is_full &&
    ((kind == iis_pkg::KIND_ADD && !hit && !join_left && !join_right) ||
     (kind == iis_pkg::KIND_REMOVE && hit && !cut_start && !cut_end));

  always_comb begin
    rd_addr = idx[IdxW-1:0];
    if (cmd.shift_up) begin
      rd_addr = sh_idx[IdxW-1:0] - IdxW'(1);
    end else if (cmd.shift_down) begin
      rd_addr = sh_idx[IdxW-1:0] + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_start <= mem_start[rd_addr];
    rd_end <= mem_end[rd_addr];
  end

  // Scan: idx issues reads; rd_idx marks the entry whose data arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_valid <= 1'b0;
      result <= '0;
      need_up <= 1'b0;
      need_down <= 1'b0;
    end else begin
      if (cmd.load) begin
        kind <= in_word.kind;
        key <= 33'(in_word.key);
      end
      if (cmd.scan_start) begin
        idx <= '0;
        rd_valid <= 1'b0;
        f <= count;
        f_set <= 1'b0;
        nfree <= key;
        nfree_stop <= 1'b0;
        prev_end <= '0;
        need_up <= 1'b0;
        need_down <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_valid <= idx < count;
        rd_idx <= idx;
        idx <= idx + CntW'(1);
        if (rd_valid) begin
          if (!f_set && rd_end > key) begin
            f_set <= 1'b1;
            f <= rd_idx;
            f_start <= rd_start;
            f_end <= rd_end;
          end else if (!f_set) begin
            prev_end <= rd_end;
          end
          if (!nfree_stop) begin
            if (rd_start > nfree) begin
              nfree_stop <= 1'b1;
            end else if (rd_end > nfree) begin
              nfree <= rd_end;
            end
          end
        end
      end
      if (cmd.decide) begin
        refused <= full;
        if (kind == iis_pkg::KIND_ADD && !hit) begin
          if (join_left && join_right) begin
            mem_end[f[IdxW-1:0] - IdxW'(1)] <= f_end;
            sh_idx <= f;
            need_down <= 1'b1;
          end else if (join_left) begin
            mem_end[f[IdxW-1:0] - IdxW'(1)] <= key1;
          end else if (join_right) begin
            mem_start[f[IdxW-1:0]] <= key;
          end else if (!is_full) begin
            sh_idx <= count;
            sh_stop <= f;
            ins_start <= key;
            ins_end <= key1;
            need_up <= 1'b1;
          end
        end else if (kind == iis_pkg::KIND_REMOVE && hit) begin
          if (cut_start && cut_end) begin
            sh_idx <= f;
            need_down <= 1'b1;
          end else if (cut_start) begin
            mem_start[f[IdxW-1:0]] <= key1;
          end else if (cut_end) begin
            mem_end[f[IdxW-1:0]] <= key;
          end else if (!is_full) begin
            mem_end[f[IdxW-1:0]] <= key;
            sh_idx <= count;
            sh_stop <= f + CntW'(1);
            ins_start <= key1;
            ins_end <= f_end;
            need_up <= 1'b1;
          end
        end
        rd_valid <= 1'b0;
      end
      // Shift up: move entry i-1 to i, from count down to the insert slot.
      if (cmd.shift_up) begin
        if (sh_idx == sh_stop) begin
          mem_start[sh_idx[IdxW-1:0]] <= ins_start;
          mem_end[sh_idx[IdxW-1:0]] <= ins_end;
          count <= count + CntW'(1);
          need_up <= 1'b0;
        end else if (rd_valid) begin
          mem_start[sh_idx[IdxW-1:0]] <= rd_start;
          mem_end[sh_idx[IdxW-1:0]] <= rd_end;
          sh_idx <= sh_idx - CntW'(1);
          rd_valid <= 1'b0;
        end else begin
          rd_valid <= 1'b1;
        end
      end
      // Shift down: move entry i+1 to i, from the dropped slot to the end.
      if (cmd.shift_down) begin
        if (sh_idx + CntW'(1) >= count) begin
          count <= count - CntW'(1);
          need_down <= 1'b0;
        end else if (rd_valid) begin
          mem_start[sh_idx[IdxW-1:0]] <= rd_start;
          mem_end[sh_idx[IdxW-1:0]] <= rd_end;
          sh_idx <= sh_idx + CntW'(1);
          rd_valid <= 1'b0;
        end else begin
          rd_valid <= 1'b1;
        end
      end
      if (cmd.finish) begin
        result <= '{
          was_member: hit,
          member_found: f_set,
          next_member: f_set ? ((f_start > key) ? f_start[31:0] : key[31:0]) : 32'd0,
          next_free: nfree[31:0],
          table_full: refused,
          set_empty: count == '0
        };
      end
    end
  end

  assign status.scan_done = cmd.scan_step && (idx > count);
  assign status.need_up = need_up;
  assign status.need_down = need_down;
  assign status.shift_up_done = cmd.shift_up && sh_idx == sh_stop;
  assign status.shift_down_done = cmd.shift_down && (sh_idx + CntW'(1) >= count);

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(iis_pkg::MaxRanges)) else $error("range count overflow");
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(need_up && need_down)) else $error("insert and drop together");
  a_full_nochange: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && count == CntW'(iis_pkg::MaxRanges) |=> $stable(count))
    else $error("count changed on full table");
`endif

endmodule

/* hw/rtl/integer_interval_set.sv */
// Top level of the integer interval set: controller, datapath and output register.
// Depends on iis_pkg, iis_ctrl and iis_dp.
//
//   channel   direction  word
//   in        input      iis_pkg::in_word_t  (kind, key)
//   out       output     iis_pkg::out_word_t (six result fields)
//
// One word at a time: a lookup scans every range held, and when the table shifts
// by one entry, each entry moved goes through the single read port of the range
// table. Synchronous reset empties the set. The result sits in an output register;
// the next word is taken while it waits, but a third waits for the slot.
module integer_interval_set (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iis_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iis_pkg::out_word_t   out_data
);

  iis_pkg::cmd_t cmd;
  iis_pkg::status_t status;
  iis_pkg::out_word_t result;

  iis_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .out_busy(out_valid && !out_ready),
    .status(status), .in_ready(in_ready), .cmd(cmd)
  );

  iis_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_data), .status(status), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    out_data = result;
  end

endmodule
